// ----- rtl/i2cm_pkg.sv -----
// Package for the I2C master bit engine: operation codes, the input beat,
// result beat and engine state types. No dependencies.
package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Phase counts of the data-bit parts of the byte sequences, and the last sub-phase of a write bit
    localparam logic [4:0] WRITE_BIT_PHASES = 5'd24;
    localparam logic [4:0] READ_BIT_PHASES  = 5'd16;
    localparam logic [1:0] SUB_LAST         = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } i2cm_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_received;
    } i2cm_result_t;

    typedef struct packed {
        op_t        operation;
        logic [4:0] phase_step;
        logic [1:0] bit_phase;
        logic [3:0] bit_counter;
        logic [7:0] shift_byte;
        logic       scl_level;
        logic       sda_level;
        logic       ack_flag;
        logic       ack_to_send;
        logic [7:0] read_byte;
        logic       ack_pending;
    } i2cm_state_t;

endpackage

// ----- rtl/i2cm_if.sv -----
// Channel interfaces of the I2C master bit engine: tick input and result output.
// Each carries valid, ready and the beat's fields. No dependencies.
interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, command, write_data, send_ack, sda_in, input ready);
    modport sink   (input valid, command, write_data, send_ack, sda_in, output ready);
endinterface

interface i2cm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_received, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_received, output ready);
endinterface

// ----- rtl/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: engine state register, step logic
// and result register. Depends on i2cm_pkg, i2cm_if.sv and i2cm_step.
//
// Usage:
//   tick   - one beat per bit-timing tick from an external divider. It carries
//            the SDA level seen at the end of the previous tick and, while the
//            engine is idle, a command: start, stop, write byte or read byte.
//            A command given while a sequence runs, or an unused code, is ignored.
//   result - one beat per accepted tick: SCL and SDA drive for that tick, busy,
//            a done pulse on the last tick of a sequence, the last read byte and
//            the acknowledge seen after the last write.
//   Each tick beat is handled by combinational step logic: the result is in the
//   output register on the cycle after acceptance, and one tick beat can be
//   taken every cycle while the receiver takes each result. Throughput is set by the
//   single result register; a start or stop takes 4 ticks, a write 28 and a read 21.
//   When the receiver stalls, the result register holds its beat and tick
//   ready goes low until that beat is taken; ready comes back in the same
//   cycle the receiver takes the beat, so there is no bubble.
//   Reset puts the engine idle with SCL and SDA released, flags cleared and
//   the result register empty.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    i2cm_tick_if.sink     tick,
    i2cm_result_if.source result
);

    i2cm_state_t  state_reg;
    i2cm_state_t  state_next;
    i2cm_item_t   item;
    i2cm_result_t res_next;
    i2cm_result_t res_reg;
    logic         out_valid_reg;
    logic         accept;

    assign item.command    = tick.command;
    assign item.write_data = tick.write_data;
    assign item.send_ack   = tick.send_ack;
    assign item.sda_in     = tick.sda_in;

    // Take a new tick whenever the result register is free or being emptied
    assign tick.ready = ~out_valid_reg | result.ready;
    assign accept     = tick.valid & tick.ready;

    i2cm_step u_step (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Idle, SCL and SDA released, everything else cleared
            state_reg     <= '{operation: OP_IDLE, scl_level: 1'b1, sda_level: 1'b1,
                               default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.scl_out      = res_reg.scl_out;
    assign result.sda_out      = res_reg.sda_out;
    assign result.busy_res     = res_reg.busy_res;
    assign result.done_res     = res_reg.done_res;
    assign result.read_data    = res_reg.read_data;
    assign result.ack_received = res_reg.ack_received;

    // A completed sequence leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.done_res |=> state_reg.operation == OP_IDLE)
        else $error("engine not idle after done");

    // Idle engine always restarts from phase zero
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.operation == OP_IDLE |-> state_reg.phase_step == 5'd0)
        else $error("idle engine with nonzero phase");

    // Pending acknowledge sample only exists between sequences
    a_ack_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ack_pending |-> state_reg.operation == OP_IDLE)
        else $error("ack pending while busy");

    // A done beat is always a busy beat
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done_res |-> res_reg.busy_res)
        else $error("done without busy");

    // Empty result register never blocks the tick channel
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> tick.ready)
        else $error("tick stalled with empty result register");

endmodule

// ----- rtl/i2cm_step.sv -----
// Per-tick next-state and result logic of the I2C master bit engine.
// Depends on i2cm_pkg.
module i2cm_step
    import i2cm_pkg::*;
(
    input  i2cm_state_t  state,
    input  i2cm_item_t   item,
    output i2cm_state_t  state_next,
    output i2cm_result_t res
);

    always_comb
    begin
        i2cm_state_t s;
        logic        last;
        logic        scl_after;
        s         = state;
        last      = 1'b0;
        scl_after = 1'b0;
        res       = '0;

        // Latch a pending write acknowledge, then take a new command
        if (s.operation == OP_IDLE)
        begin
            if (s.ack_pending)
            begin
                s.ack_flag    = ~item.sda_in;
                s.ack_pending = 1'b0;
            end
            if (item.command >= 3'(OP_START) && item.command <= 3'(OP_READ))
            begin
                s.operation   = op_t'(item.command);
                s.phase_step  = '0;
                s.bit_phase   = '0;
                s.bit_counter = '0;
                if (item.command == 3'(OP_WRITE))
                    s.shift_byte = item.write_data;
                if (item.command == 3'(OP_READ))
                begin
                    s.shift_byte  = '0;
                    s.ack_to_send = item.send_ack;
                end
            end
        end

        unique case (s.operation)
            OP_START:
            begin
                case (s.phase_step)
                    5'd0:    s.scl_level = 1'b1;
                    5'd1:    s.sda_level = 1'b1;
                    5'd2:    s.sda_level = 1'b0;
                    default:
                    begin
                        s.scl_level = 1'b0;
                        last        = 1'b1;
                    end
                endcase
            end
            OP_STOP:
            begin
                case (s.phase_step)
                    5'd0:    s.scl_level = 1'b0;
                    5'd1:    s.sda_level = 1'b0;
                    5'd2:    s.scl_level = 1'b1;
                    default:
                    begin
                        s.sda_level = 1'b1;
                        last        = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                if (s.phase_step < WRITE_BIT_PHASES)
                begin
                    case (s.bit_phase)
                        2'd0:    s.scl_level = 1'b0;
                        2'd1:
                        begin
                            s.sda_level   = s.shift_byte[7];
                            s.shift_byte  = {s.shift_byte[6:0], 1'b0};
                            s.bit_counter = s.bit_counter + 4'd1;
                        end
                        default: s.scl_level = 1'b1;
                    endcase
                    s.bit_phase = (s.bit_phase == SUB_LAST) ? 2'd0 : s.bit_phase + 2'd1;
                end
                else if (s.phase_step == 5'd24 || s.phase_step == 5'd25)
                    s.scl_level = 1'b0;
                else if (s.phase_step == 5'd26)
                    s.sda_level = 1'b1;
                else
                begin
                    s.scl_level = 1'b1;
                    last        = 1'b1;
                    scl_after   = 1'b1;
                end
            end
            OP_READ:
            begin
                if (s.phase_step == 5'd0)
                    s.scl_level = 1'b0;
                else if (s.phase_step <= READ_BIT_PHASES)
                begin
                    if (s.phase_step == 5'd1)
                        s.sda_level = 1'b1;
                    if (s.phase_step[0])
                        s.scl_level = 1'b1;
                    else
                    begin
                        s.shift_byte  = {s.shift_byte[6:0], item.sda_in};
                        s.bit_counter = s.bit_counter + 4'd1;
                        s.scl_level   = 1'b0;
                    end
                end
                else if (s.phase_step == 5'd17)
                    s.scl_level = 1'b0;
                else if (s.phase_step == 5'd18)
                    s.sda_level = ~s.ack_to_send;
                else if (s.phase_step == 5'd19)
                    s.scl_level = 1'b1;
                else
                begin
                    s.scl_level = 1'b0;
                    s.read_byte = s.shift_byte;
                    last        = 1'b1;
                end
            end
            default: ;
        endcase

        if (s.operation != OP_IDLE)
        begin
            res.busy_res = 1'b1;
            s.phase_step = s.phase_step + 5'd1;
        end

        res.scl_out = s.scl_level;
        res.sda_out = s.sda_level;

        // Close the sequence; after a write, drop SCL and wait for the ack level
        if (last)
        begin
            s.operation  = OP_IDLE;
            s.phase_step = '0;
            if (scl_after)
            begin
                s.scl_level   = 1'b0;
                s.ack_pending = 1'b1;
            end
        end

        res.done_res     = last;
        res.read_data    = s.read_byte;
        res.ack_received = s.ack_flag;
        state_next       = s;
    end

endmodule
